// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define CBI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define CBI_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/cbi_pkg.sv =====
// Shared types, field layout and constants of the cyclic breakpoint interpolator.
package cbi_pkg;

  // Time format: unsigned Q0.TIME_FRAC_BITS, one extra bit holds a full cycle
  localparam int TIME_FRAC_BITS = 16;
  localparam int TIME_W         = TIME_FRAC_BITS + 1;
  localparam logic [TIME_W-1:0] TIME_FULL = TIME_W'(1) << TIME_FRAC_BITS;

  // Port field widths
  localparam int VALUE_W       = 32;
  localparam int PORT_RANK_W   = 4;
  localparam int COUNT_W       = 5;
  localparam int DEF_MAX_NODES = 16;

  // Slave-side tdata layout, lowest bit first
  localparam int IN_RANK_OFF     = 0;
  localparam int IN_NTIME_OFF    = IN_RANK_OFF + PORT_RANK_W;
  localparam int IN_NVAL_OFF     = IN_NTIME_OFF + TIME_W;
  localparam int IN_QTIME_OFF    = IN_NVAL_OFF + VALUE_W;
  localparam int IN_REMEMBER_OFF = IN_QTIME_OFF + TIME_W;
  localparam int S_TDATA_W       = ((IN_REMEMBER_OFF + 1 + 7) / 8) * 8;

  // Master-side tdata layout, lowest bit first
  localparam int M_VALUE_OFF = 0;
  localparam int M_RANK_OFF  = M_VALUE_OFF + VALUE_W;
  localparam int M_TDATA_W   = ((M_RANK_OFF + PORT_RANK_W + 7) / 8) * 8;

  // Item kinds carried in s_tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Quotient of the interpolation fraction, 0 .. 1.0 inclusive
  localparam int FRAC_W = TIME_FRAC_BITS + 1;

  typedef struct packed {
    logic [TIME_W-1:0]         tm;
    logic signed [VALUE_W-1:0] val;
  } node_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_PRIME,
    ST_SEARCH,
    ST_EVAL,
    ST_DIVIDE,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } state_t;

  // Clamp a time to one full cycle
  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] t);
    return (t > TIME_FULL) ? TIME_FULL : t;
  endfunction

endpackage

// ===== hdl/cyclic_breakpoint_interpolator.sv =====
// Cyclic breakpoint interpolator: breakpoint table in memory, walk, divide, blend.
//
// Slave channel (s_*): one beat is one item. s_tuser selects a load (0), which
// writes one breakpoint at its rank, or a query (1), which asks for the curve
// value at query_time. Master channel (m_*): one result beat per query, none
// per load. cfg_wr_en/cfg_wr_data write node_count; the user must write it only
// while the block idles, the block does not enforce this. Loads are accepted
// back to back. A query holds s_tready low until its result is in the output
// register. An empty curve goes from idle straight to the finish state; a hit on
// a breakpoint runs start, prime, search, eval and finish; an interpolation also
// runs divide, mul and add between eval and finish. The walk visits from 1 to
// n + 1 intervals, n being node_count limited to MAX_NODES.
// The walk reads one table entry per cycle from the table memory, and the
// fraction comes from the bit-serial divider.
// The output register holds a finished result while the receiver stalls;
// loads and the next query are still taken meanwhile, and a later query waits
// in its last state until the register is free.
// Reset (rst, synchronous) clears node_count, the search start rank and the
// output valid; the breakpoint table is undefined until loaded.
module cyclic_breakpoint_interpolator #(
  parameter int MAX_NODES = cbi_pkg::DEF_MAX_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: node_rank, node_time, node_value, query_time, remember
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cbi_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: kind
  input  logic [0:0]                    s_tuser,
  // m_tdata: curve_value, left_rank
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cbi_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: curve_empty
  output logic [0:0]                    m_tuser,
  input  logic                          cfg_wr_en,
  input  logic [cbi_pkg::COUNT_W-1:0]   cfg_wr_data
);
  import cbi_pkg::*;

  localparam int RANK_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int RCMP_W = (CNT_W > PORT_RANK_W) ? CNT_W : PORT_RANK_W;
  localparam int DIFF_W = VALUE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  // Next rank around the ring of cnt breakpoints
  function automatic logic [RANK_W-1:0] ring_succ(input logic [RANK_W-1:0] r,
                                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(r) + CNT_W'(1);
    return (inc == cnt) ? '0 : RANK_W'(inc);
  endfunction

  state_t state, state_next;

  // Input fields
  logic [PORT_RANK_W-1:0] in_rank;
  logic [TIME_W-1:0]      in_ntime;
  logic [VALUE_W-1:0]     in_nval;
  logic [TIME_W-1:0]      in_qtime;
  logic                   in_remember;
  logic                   s_acc;
  logic                   load_ok;

  // Configuration and state
  logic [COUNT_W-1:0]     node_count;
  logic [CNT_W-1:0]       n_eff;
  logic [RANK_W-1:0]      search_start;
  logic [RANK_W-1:0]      start_cl;

  // Table memory
  node_entry_t            mem [MAX_NODES];
  logic                   wr_en;
  logic                   rd_en;
  logic [RANK_W-1:0]      rd_addr;
  node_entry_t            rd_data;

  // Query working registers
  logic [TIME_W-1:0]      t_q;
  logic                   remember_q;
  logic [RANK_W-1:0]      l_rank;
  logic [RANK_W-1:0]      r_rank;
  logic [CNT_W-1:0]       step;
  node_entry_t            l_entry;
  node_entry_t            r_entry;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [VALUE_W-1:0]     res_value;
  logic                   res_empty;

  // Walk and evaluation terms
  logic                   in_span;
  logic                   found;
  logic                   hit_l;
  logic                   hit_r;
  logic [TIME_W:0]        d_w;
  logic [TIME_W:0]        d_adj;
  logic [TIME_W-1:0]      d_fin;
  logic [TIME_W:0]        x_w;
  logic [TIME_W:0]        x_adj;
  logic [TIME_W-1:0]      x_fin;

  // Divider hookup
  logic                   div_start;
  logic                   div_done;
  logic [FRAC_W-1:0]      frac;

  // Output register
  logic                   out_free;

  // Field unpacking
  assign in_rank     = s_tdata[IN_RANK_OFF +: PORT_RANK_W];
  assign in_ntime    = s_tdata[IN_NTIME_OFF +: TIME_W];
  assign in_nval     = s_tdata[IN_NVAL_OFF +: VALUE_W];
  assign in_qtime    = s_tdata[IN_QTIME_OFF +: TIME_W];
  assign in_remember = s_tdata[IN_REMEMBER_OFF];
  assign s_acc       = s_tvalid && s_tready;
  assign load_ok     = (RCMP_W'(in_rank) < RCMP_W'(MAX_NODES));
  assign wr_en       = s_acc && (s_tuser[0] == KIND_LOAD) && load_ok;
  assign out_free    = !m_tvalid || m_tready;

  // Breakpoints in use, limited to the table depth
  assign n_eff = (CMP_W'(node_count) > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(node_count);
  assign start_cl = (CNT_W'(search_start) > (n_eff - CNT_W'(1)))
                    ? RANK_W'(n_eff - CNT_W'(1)) : search_start;

  // Bracket test: l_entry against the entry just read at r_rank
  always_comb begin
    if (r_rank == '0) begin
      in_span = (t_q >= l_entry.tm) || (t_q <= rd_data.tm);
    end else begin
      in_span = (t_q >= l_entry.tm) && (t_q <= rd_data.tm);
    end
    // After a full lap with no bracket the pair is back at the start rank
    found = in_span || (step == n_eff);
  end

  // Wrapped interval length and distance
  always_comb begin
    hit_l = (t_q == l_entry.tm);
    hit_r = (t_q == r_entry.tm);
    d_w   = (TIME_W+1)'(r_entry.tm) - (TIME_W+1)'(l_entry.tm);
    d_adj = d_w[TIME_W] ? d_w + (TIME_W+1)'(TIME_FULL) : d_w;
    d_fin = (d_adj == '0) ? TIME_FULL : TIME_W'(d_adj);
    x_w   = (TIME_W+1)'(t_q) - (TIME_W+1)'(l_entry.tm);
    x_adj = x_w[TIME_W] ? x_w + (TIME_W+1)'(TIME_FULL) : x_w;
    x_fin = (x_adj > (TIME_W+1)'(d_fin)) ? d_fin : TIME_W'(x_adj);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc && (s_tuser[0] == KIND_QUERY)) begin
          state_next = (n_eff == '0) ? ST_FINISH : ST_START;
        end
      end
      ST_START:  state_next = ST_PRIME;
      ST_PRIME:  state_next = ST_SEARCH;
      ST_SEARCH: if (found) state_next = ST_EVAL;
      ST_EVAL:   state_next = (hit_l || hit_r) ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_ADD;
      ST_ADD:    state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = r_rank;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_START: begin
        rd_en   = 1'b1;
        rd_addr = start_cl;
      end
      ST_PRIME: rd_en = 1'b1;
      ST_SEARCH: begin
        rd_en   = !found;
        rd_addr = ring_succ(r_rank, n_eff);
      end
      ST_EVAL: div_start = !(hit_l || hit_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Breakpoint table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[RANK_W'(in_rank)] <= '{tm: sat_time(in_ntime), val: in_nval};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Configuration register and remembered start rank
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= '0;
      search_start <= '0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (state == ST_START) begin
        search_start <= start_cl;
      end else if ((state == ST_SEARCH) && found && remember_q) begin
        search_start <= l_rank;
      end
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          t_q        <= sat_time(in_qtime);
          remember_q <= in_remember;
          l_rank     <= '0;
          res_value  <= '0;
          res_empty  <= 1'b1;
        end
      end
      ST_START: begin
        l_rank    <= start_cl;
        r_rank    <= ring_succ(start_cl, n_eff);
        step      <= '0;
        res_empty <= 1'b0;
      end
      ST_PRIME: l_entry <= rd_data;
      ST_SEARCH: begin
        if (found) begin
          r_entry <= rd_data;
        end else begin
          l_entry <= rd_data;
          l_rank  <= r_rank;
          r_rank  <= ring_succ(r_rank, n_eff);
          step    <= step + CNT_W'(1);
        end
      end
      ST_EVAL: begin
        if (hit_l) begin
          res_value <= l_entry.val;
        end else if (hit_r) begin
          res_value <= r_entry.val;
        end
        diff <= DIFF_W'(r_entry.val) - DIFF_W'(l_entry.val);
      end
      ST_MUL: prod <= diff * $signed({1'b0, frac});
      ST_ADD: res_value <= l_entry.val + VALUE_W'(prod >>> TIME_FRAC_BITS);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_tdata <= M_TDATA_W'({PORT_RANK_W'(l_rank), res_value});
      m_tuser <= res_empty;
    end
  end

  cbi_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (x_fin),
    .den   (d_fin),
    .done  (div_done),
    .quot  (frac)
  );

endmodule

// ===== hdl/cbi_divider.sv =====
// Restoring divider for the interpolation fraction (num << TIME_FRAC_BITS) / den.
module cbi_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cbi_pkg::TIME_W-1:0] num,
  input  logic [cbi_pkg::TIME_W-1:0] den,
  output logic                       done,
  output logic [cbi_pkg::FRAC_W-1:0] quot
);
  import cbi_pkg::*;

  localparam int CNT_W = $clog2(TIME_FRAC_BITS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [TIME_W-1:0]   rem;
  logic [TIME_W-1:0]   dvs;
  logic [TIME_W:0]     rem2;
  logic                q_bit;
  logic                int_bit;

  // num never exceeds den, so the integer bit is a single compare
  assign int_bit = (num >= den);
  assign rem2    = {rem, 1'b0};
  assign q_bit   = (rem2 >= {1'b0, dvs});

  // Control: one fraction bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TIME_FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= den;
      rem  <= int_bit ? (num - den) : num;
      quot <= FRAC_W'(int_bit);
    end else if (busy) begin
      rem  <= q_bit ? TIME_W'(rem2 - {1'b0, dvs}) : TIME_W'(rem2);
      quot <= {quot[FRAC_W-2:0], q_bit};
    end
  end

endmodule

// ===== hdl/cbi_checker.sv =====
// Port-level checks of the cyclic breakpoint interpolator, bound to the top level.
`include "assert_macros.svh"

module cbi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [0:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [cbi_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser
);
  import cbi_pkg::*;

  // Reset empties the output register
  `CBI_ASSERT_RST(a_rst_clears_out, clk, rst |=> !m_tvalid, "output valid after reset")

  // A stalled result beat holds
  `CBI_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // An empty-curve result carries zero value and rank
  `CBI_ASSERT(a_empty_zero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata[M_RANK_OFF+PORT_RANK_W-1:0] == '0, "empty result not zero")

  // An accepted query holds off the next item in the cycle after it
  `CBI_ASSERT(a_query_busy, clk, rst, s_tvalid && s_tready && (s_tuser[0] == KIND_QUERY) |=> !s_tready, "query did not stall input")

endmodule

bind cyclic_breakpoint_interpolator cbi_checker u_cbi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
